### src/assert_macros.svh
// assert_macros.svh: shared concurrent assertion macros
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge outside reset
`define ASSERT_HOLDS(name, clock, reset_n, expr, msg) \
    name: assert property (@(posedge clock) disable iff (!reset_n) (expr)) else $error(msg);

// Condition at one edge implies the expression at the next edge
`define ASSERT_NEXT(name, clock, reset_n, cond, expr, msg) \
    name: assert property (@(posedge clock) disable iff (!reset_n) (cond) |=> (expr)) else $error(msg);

`endif

### src/hsvr_pkg.sv
`timescale 1ns / 1ps
// ============================================================================
// hsvr_pkg
// Shared types, constants and scaling functions for the rainbow HSV converter.
// ============================================================================
package hsvr_pkg;

    // Default depth of the queue between front and back
    localparam int QUEUE_DEPTH_DEF = 4;

    // Rainbow anchors
    localparam logic [7:0] ANCHOR_FULL = 8'd255;
    localparam logic [7:0] ANCHOR_HI   = 8'd171;
    localparam logic [7:0] ANCHOR_MID  = 8'd170;
    localparam logic [7:0] ANCHOR_LO   = 8'd85;

    // Ramp scales: one third and two thirds of 256
    localparam logic [7:0] THIRD_SCALE     = 8'(256 / 3);
    localparam logic [7:0] TWOTHIRDS_SCALE = 8'((256 * 2) / 3);

    localparam logic [7:0] CHAN_FULL = 8'd255;

    // Hue segment, top three hue bits
    typedef enum logic [2:0] {
        SEG_RED    = 3'd0,
        SEG_ORANGE = 3'd1,
        SEG_YELLOW = 3'd2,
        SEG_GREEN  = 3'd3,
        SEG_AQUA   = 3'd4,
        SEG_BLUE   = 3'd5,
        SEG_PURPLE = 3'd6,
        SEG_PINK   = 3'd7
    } hsvr_seg_t;

    // Classified item handed from front to back
    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic [7:0] desat;     // saturation floor
        logic       sat_full;
        logic       sat_zero;
        logic [7:0] v2;        // video-squared brightness
        logic       val_full;
    } hsvr_work_t;

    // (v * (s + 1)) >> 8; the product stays below 2^16
    function automatic logic [7:0] mul_scale(input logic [7:0] v, input logic [7:0] s);
        logic [15:0] prod;
        prod = 16'(v) * (16'(s) + 16'd1);
        return prod[15:8];
    endfunction

    // (v * s) >> 8, plus one when both are nonzero
    function automatic logic [7:0] mul_video(input logic [7:0] v, input logic [7:0] s);
        logic [15:0] prod;
        logic        bump;
        prod = 16'(v) * 16'(s);
        bump = (v != 8'd0) && (s != 8'd0);
        return prod[15:8] + {7'd0, bump};
    endfunction

endpackage

### src/hsvr_if.sv
`timescale 1ns / 1ps
// ============================================================================
// hsvr_if
// Valid/ready channels for HSV items in and RGB items out.
// ============================================================================

// HSV input channel
interface hsvr_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] hue;
    logic [7:0] saturation;
    logic [7:0] brightness;

    modport source
    (
        output valid, hue, saturation, brightness,
        input  ready
    );
    modport sink
    (
        input  valid, hue, saturation, brightness,
        output ready
    );
endinterface

// RGB output channel
interface hsvr_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;

    modport source
    (
        output valid, red, green, blue,
        input  ready
    );
    modport sink
    (
        input  valid, red, green, blue,
        output ready
    );
endinterface

### src/hsvr_front.sv
`timescale 1ns / 1ps
// ============================================================================
// hsvr_front
// Accepts HSV items, picks the hue segment, builds the base rainbow color
// and the saturation and brightness scale terms, and registers the result.
// ============================================================================
module hsvr_front
    import hsvr_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    hsvr_in_if.sink     pixel,
    output logic        work_valid,
    input  logic        work_ready,
    output hsvr_work_t  work
);

    logic       valid_reg;
    hsvr_work_t work_reg;
    hsvr_work_t work_next;
    logic       take;

    logic [7:0] ramp;
    logic [7:0] third;
    logic [7:0] twothirds;
    logic [7:0] desat_n;
    hsvr_seg_t  seg;

    // Stage register is free or drains this cycle
    assign pixel.ready = !valid_reg || work_ready;
    assign take        = pixel.valid && pixel.ready;

    // Ramp terms and segment choice
    always_comb
    begin
        ramp      = {pixel.hue[4:0], 3'b000};
        third     = mul_scale(ramp, THIRD_SCALE);
        twothirds = mul_scale(ramp, TWOTHIRDS_SCALE);
        seg       = hsvr_seg_t'(pixel.hue[7:5]);
        desat_n   = ~pixel.saturation;

        work_next.desat    = mul_video(desat_n, desat_n);
        work_next.sat_full = (pixel.saturation == CHAN_FULL);
        work_next.sat_zero = (pixel.saturation == 8'd0);
        work_next.v2       = mul_video(pixel.brightness, pixel.brightness);
        work_next.val_full = (pixel.brightness == CHAN_FULL);

        case (seg)
            SEG_RED:
            begin
                work_next.red   = ANCHOR_FULL - third;
                work_next.green = third;
                work_next.blue  = 8'd0;
            end
            SEG_ORANGE:
            begin
                work_next.red   = ANCHOR_HI;
                work_next.green = ANCHOR_LO + third;
                work_next.blue  = 8'd0;
            end
            SEG_YELLOW:
            begin
                work_next.red   = ANCHOR_HI - twothirds;
                work_next.green = ANCHOR_MID + third;
                work_next.blue  = 8'd0;
            end
            SEG_GREEN:
            begin
                work_next.red   = 8'd0;
                work_next.green = ANCHOR_FULL - third;
                work_next.blue  = third;
            end
            SEG_AQUA:
            begin
                work_next.red   = 8'd0;
                work_next.green = ANCHOR_HI - twothirds;
                work_next.blue  = ANCHOR_LO + twothirds;
            end
            SEG_BLUE:
            begin
                work_next.red   = third;
                work_next.green = 8'd0;
                work_next.blue  = ANCHOR_FULL - third;
            end
            SEG_PURPLE:
            begin
                work_next.red   = ANCHOR_LO + third;
                work_next.green = 8'd0;
                work_next.blue  = ANCHOR_HI - third;
            end
            SEG_PINK:
            begin
                work_next.red   = ANCHOR_MID + third;
                work_next.green = 8'd0;
                work_next.blue  = ANCHOR_LO - third;
            end
            default:
            begin
                work_next.red   = 8'd0;
                work_next.green = 8'd0;
                work_next.blue  = 8'd0;
            end
        endcase
    end

    // Valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (pixel.ready)
        begin
            valid_reg <= pixel.valid;
        end
    end

    // Payload
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            work_reg <= work_next;
        end
    end

    assign work_valid = valid_reg;
    assign work       = work_reg;

endmodule

### src/hsvr_fifo.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"
// ============================================================================
// hsvr_fifo
// Short queue of classified items between front and back.
// ============================================================================
module hsvr_fifo
    import hsvr_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push_valid,
    output logic        push_ready,
    input  hsvr_work_t  push_data,
    output logic        pop_valid,
    input  logic        pop_ready,
    output hsvr_work_t  pop_data
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    hsvr_work_t             mem_reg [DEPTH];
    logic [PTR_W-1:0]       wr_ptr_reg;
    logic [PTR_W-1:0]       wr_ptr_next;
    logic [PTR_W-1:0]       rd_ptr_reg;
    logic [PTR_W-1:0]       rd_ptr_next;
    logic [CNT_W-1:0]       count_reg;
    logic [CNT_W-1:0]       count_next;
    logic                   push_fire;
    logic                   pop_fire;

    assign push_ready = (count_reg != CNT_W'(DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign push_fire  = push_valid && push_ready;
    assign pop_fire   = pop_valid && pop_ready;
    assign pop_data   = mem_reg[rd_ptr_reg];

    // Pointer and count update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push_fire)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (pop_fire)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (push_fire && !pop_fire)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (pop_fire && !push_fire)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Storage
    always_ff @(posedge clk)
    begin
        if (push_fire)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

    // Fill level bounds and bookkeeping
    `ASSERT_HOLDS(a_count_bound, clk, rst_n, count_reg <= CNT_W'(DEPTH), "queue overfilled")
    `ASSERT_NEXT(a_push_grows, clk, rst_n, push_fire && !pop_fire, count_reg == CNT_W'($past(count_reg) + 1'b1), "push lost")
    `ASSERT_NEXT(a_pop_shrinks, clk, rst_n, pop_fire && !push_fire, count_reg == CNT_W'($past(count_reg) - 1'b1), "pop lost")

endmodule

### src/hsvr_back.sv
`timescale 1ns / 1ps
// ============================================================================
// hsvr_back
// Applies saturation scaling and floor, then brightness scaling, in two
// elastic stages; the second stage is the output register.
// ============================================================================
module hsvr_back
    import hsvr_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        work_valid,
    output logic        work_ready,
    input  hsvr_work_t  work,
    hsvr_out_if.source  color
);

    logic       s1_valid_reg;
    logic       s1_ready;
    logic [7:0] s1_red_reg,   s1_red_next;
    logic [7:0] s1_green_reg, s1_green_next;
    logic [7:0] s1_blue_reg,  s1_blue_next;
    logic [7:0] s1_v2_reg;
    logic       s1_val_full_reg;

    logic       out_valid_reg;
    logic       out_ready;
    logic [7:0] out_red_reg,   out_red_next;
    logic [7:0] out_green_reg, out_green_next;
    logic [7:0] out_blue_reg,  out_blue_next;
    logic [7:0] keep;

    assign out_ready  = !out_valid_reg || color.ready;
    assign s1_ready   = !s1_valid_reg || out_ready;
    assign work_ready = s1_ready;

    // Saturation: scale down and add the floor; full saturation passes the color, zero gives white
    always_comb
    begin
        keep = ~work.desat;
        if (work.sat_full)
        begin
            s1_red_next   = work.red;
            s1_green_next = work.green;
            s1_blue_next  = work.blue;
        end
        else if (work.sat_zero)
        begin
            s1_red_next   = CHAN_FULL;
            s1_green_next = CHAN_FULL;
            s1_blue_next  = CHAN_FULL;
        end
        else
        begin
            s1_red_next   = mul_scale(work.red, keep) + work.desat;
            s1_green_next = mul_scale(work.green, keep) + work.desat;
            s1_blue_next  = mul_scale(work.blue, keep) + work.desat;
        end
    end

    // Brightness: scale all channels, black when the square is zero, unchanged at full brightness
    always_comb
    begin
        if (s1_val_full_reg)
        begin
            out_red_next   = s1_red_reg;
            out_green_next = s1_green_reg;
            out_blue_next  = s1_blue_reg;
        end
        else if (s1_v2_reg == 8'd0)
        begin
            out_red_next   = 8'd0;
            out_green_next = 8'd0;
            out_blue_next  = 8'd0;
        end
        else
        begin
            out_red_next   = mul_scale(s1_red_reg, s1_v2_reg);
            out_green_next = mul_scale(s1_green_reg, s1_v2_reg);
            out_blue_next  = mul_scale(s1_blue_reg, s1_v2_reg);
        end
    end

    // Valid flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s1_ready)
            begin
                s1_valid_reg <= work_valid;
            end
            if (out_ready)
            begin
                out_valid_reg <= s1_valid_reg;
            end
        end
    end

    // Payload
    always_ff @(posedge clk)
    begin
        if (s1_ready && work_valid)
        begin
            s1_red_reg      <= s1_red_next;
            s1_green_reg    <= s1_green_next;
            s1_blue_reg     <= s1_blue_next;
            s1_v2_reg       <= work.v2;
            s1_val_full_reg <= work.val_full;
        end
        if (out_ready && s1_valid_reg)
        begin
            out_red_reg   <= out_red_next;
            out_green_reg <= out_green_next;
            out_blue_reg  <= out_blue_next;
        end
    end

    assign color.valid = out_valid_reg;
    assign color.red   = out_red_reg;
    assign color.green = out_green_reg;
    assign color.blue  = out_blue_reg;

endmodule

### src/hsv_rainbow_to_rgb_top.sv
`timescale 1ns / 1ps
// An accepted item passes the front register, the queue, the saturation stage and the output register in turn.
// Throughput: one item per cycle; the front register, queue and two back
// stages each pass one item a cycle while the output side takes them.
// Stalls on the output fill the back stages and the queue before pixel.ready drops.
// Reset (rst_n low, async) empties all stages and the queue; no clearing pass.
// ============================================================================
// hsv_rainbow_to_rgb_top
// Rainbow HSV to RGB converter: front classifier, queue, scaling back end.
// ============================================================================
module hsv_rainbow_to_rgb_top
    import hsvr_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    hsvr_in_if.sink     pixel,
    hsvr_out_if.source  color
);

    logic       front_valid;
    logic       front_ready;
    hsvr_work_t front_work;
    logic       back_valid;
    logic       back_ready;
    hsvr_work_t back_work;

    hsvr_front u_front
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .pixel      (pixel),
        .work_valid (front_valid),
        .work_ready (front_ready),
        .work       (front_work)
    );

    hsvr_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (front_valid),
        .push_ready (front_ready),
        .push_data  (front_work),
        .pop_valid  (back_valid),
        .pop_ready  (back_ready),
        .pop_data   (back_work)
    );

    hsvr_back u_back
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .work_valid (back_valid),
        .work_ready (back_ready),
        .work       (back_work),
        .color      (color)
    );

endmodule
